[rtl/core/bcdseg_pkg.sv]
package bcdseg_pkg;

  localparam int BCD_W          = 32;
  localparam int NUM_DIGITS     = BCD_W / 4;
  localparam int TOP_DIGITS     = 4;
  localparam int TOP_BITS       = 4 * TOP_DIGITS;
  localparam int NUM_CELLS      = 8;
  localparam int STEPS_PER_CELL = BCD_W / NUM_CELLS;
  localparam int IDX_W          = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {
    ROW_BOTTOM = 2'd0,
    ROW_MIDDLE = 2'd1,
    ROW_TOP    = 2'd2
  } row_t;

  localparam logic [1:0] ROW_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [4:0] segment_line;
    logic [7:0] pattern;
    logic       last;
  } out_t;

  // Work item travelling down the cell chain
  typedef struct packed {
    row_t             row;
    logic [BCD_W-1:0] bin;
    logic [BCD_W-1:0] acc;
  } stage_t;

  // One double-dabble step: add 3 to every digit >= 5, then shift in a bit.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] acc,
                                                    input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = acc;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (acc[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = acc[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  function automatic logic [7:0] seg_a(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h77;
      4'd1:    pat = 8'h12;
      4'd2:    pat = 8'hE3;
      4'd3:    pat = 8'hD3;
      4'd4:    pat = 8'h96;
      4'd5:    pat = 8'hD5;
      4'd6:    pat = 8'hF5;
      4'd7:    pat = 8'h13;
      4'd8:    pat = 8'hF7;
      default: pat = 8'h97;
    endcase
    return pat;
  endfunction

  function automatic logic [7:0] seg_b(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'hEE;
      4'd1:    pat = 8'hC0;
      4'd2:    pat = 8'h5E;
      4'd3:    pat = 8'hDA;
      4'd4:    pat = 8'hF0;
      4'd5:    pat = 8'hBA;
      4'd6:    pat = 8'hBE;
      4'd7:    pat = 8'hC8;
      4'd8:    pat = 8'hFE;
      default: pat = 8'hF8;
    endcase
    return pat;
  endfunction

  function automatic logic [4:0] middle_line(input logic [IDX_W-1:0] idx);
    logic [4:0] line;
    unique case (idx)
      3'd0:    line = 5'd20;
      3'd1:    line = 5'd19;
      3'd2:    line = 5'd9;
      3'd3:    line = 5'd10;
      3'd4:    line = 5'd11;
      3'd5:    line = 5'd12;
      3'd6:    line = 5'd13;
      default: line = 5'd14;
    endcase
    return line;
  endfunction

endpackage

[rtl/core/bcdseg_cell.sv]
module bcdseg_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  bcdseg_pkg::stage_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output bcdseg_pkg::stage_t data_o
);
  import bcdseg_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  // Run this cell's share of the shift steps, MSB of bin first
  always_comb begin
    logic [BCD_W-1:0] acc;
    logic [BCD_W-1:0] bin;
    acc = data_i.acc;
    bin = data_i.bin;
    for (int s = 0; s < STEPS_PER_CELL; s++) begin
      acc = dabble_step(acc, bin[BCD_W-1]);
      bin = {bin[BCD_W-2:0], 1'b0};
    end
    data_nxt     = data_i;
    data_nxt.acc = acc;
    data_nxt.bin = bin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

[rtl/core/bcdseg_emit.sv]
module bcdseg_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  bcdseg_pkg::stage_t data_i,
  output logic               out_valid,
  input  logic               out_ready,
  output bcdseg_pkg::out_t   out_data
);
  import bcdseg_pkg::*;

  logic             busy_r;
  row_t             row_r;
  logic [BCD_W-1:0] shift_r;
  logic [IDX_W-1:0] idx_r;
  logic [3:0]       digit;
  logic             last_w;
  logic             take;
  logic             fire;

  assign digit  = shift_r[BCD_W-1 -: 4];
  assign last_w = (row_r == ROW_TOP) ? (idx_r == IDX_W'(TOP_DIGITS - 1))
                                     : (idx_r == IDX_W'(NUM_DIGITS - 1));
  assign fire    = busy_r && out_ready;
  assign ready_o = !busy_r || (out_ready && last_w);
  assign take    = valid_i && ready_o;

  assign out_valid = busy_r;

  always_comb begin
    out_data.last = last_w;
    unique case (row_r)
      ROW_BOTTOM: begin
        out_data.segment_line = 5'(NUM_DIGITS - 1) - 5'(idx_r);
        out_data.pattern      = seg_a(digit);
      end
      ROW_MIDDLE: begin
        out_data.segment_line = middle_line(idx_r);
        out_data.pattern      = seg_b(digit);
      end
      default: begin
        out_data.segment_line = 5'd18 - 5'(idx_r);
        out_data.pattern      = seg_a(digit);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (take) begin
      busy_r <= 1'b1;
    end else if (fire && last_w) begin
      busy_r <= 1'b0;
    end
  end

  // Top row keeps only its low digits; align them to the top of the shifter
  always_ff @(posedge clk) begin
    if (take) begin
      row_r   <= data_i.row;
      idx_r   <= '0;
      shift_r <= (data_i.row == ROW_TOP) ?
                 {data_i.acc[TOP_BITS-1:0], {(BCD_W-TOP_BITS){1'b0}}} : data_i.acc;
    end else if (fire) begin
      idx_r   <= idx_r + 1'b1;
      shift_r <= {shift_r[BCD_W-5:0], 4'h0};
    end
  end

  a_top_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && row_r == ROW_TOP |-> idx_r < IDX_W'(TOP_DIGITS))
    else $error("top row digit index out of range");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !last_w |=> busy_r && idx_r == $past(idx_r) + 1'b1)
    else $error("run ended before its last write");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_ready |=> $stable(idx_r) && $stable(shift_r) && $stable(row_r))
    else $error("emitter state moved during stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy_r)
    else $error("emitter busy after reset");

endmodule

[rtl/core/binary_to_bcd_seven_segment_rows_unit.sv]
// Binary to BCD to seven-segment row writer.
//
// Input channel (in_valid/in_ready/in_data): one transaction carries a row
// select (func) and a 32-bit binary value. Rows 0 and 1 show value mod 10^8
// as eight digits, row 2 shows the low 16 bits mod 10^4 as four digits.
// A transaction with row select 3 is taken and dropped without any output.
// Output channel (out_valid/out_ready/out_data): one transaction per digit,
// most significant first, giving the LCD segment line and the pattern byte;
// last marks the final write of a value.
// Latency: the conversion runs through a chain of eight cells, each doing
// four shift-and-correct steps; each cell registers its result, and the
// emitter registers the finished word before out_valid rises for its first write.
// Throughput: the cell chain takes a new value every cycle unless stalled;
// the emitter is the limit, with eight writes per value for rows 0 and 1 and
// four for row 2; the next value loads in the same cycle the last write goes.
// Reset (rst_n low, synchronous) empties the chain and the emitter.
// When the receiver stalls, the current write holds steady, the chain fills
// up behind it and in_ready drops once every cell is occupied.
module binary_to_bcd_seven_segment_rows_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bcdseg_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bcdseg_pkg::out_t out_data
);
  import bcdseg_pkg::*;

  logic   valid_c [NUM_CELLS+1];
  logic   ready_c [NUM_CELLS+1];
  stage_t data_c  [NUM_CELLS+1];

  // Drop unused row selects at the door; zero-extend the top row so all rows
  // run the same 32 steps (leading zeros leave the accumulator at zero)
  always_comb begin
    data_c[0].row = row_t'(in_data.func);
    data_c[0].acc = '0;
    if (in_data.func == 2'(ROW_TOP)) begin
      data_c[0].bin = {{(BCD_W-TOP_BITS){1'b0}}, in_data.value[TOP_BITS-1:0]};
    end else begin
      data_c[0].bin = in_data.value;
    end
  end

  assign valid_c[0] = in_valid && (in_data.func != ROW_UNUSED);
  assign in_ready   = ready_c[0];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    bcdseg_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  // Serialize the finished BCD word into one write per digit
  bcdseg_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (valid_c[NUM_CELLS]),
    .ready_o   (ready_c[NUM_CELLS]),
    .data_i    (data_c[NUM_CELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
